[design/fpa_pkg.sv]
// Shared command codes and pipeline control type for the fixed-point ALU.
`timescale 1ns / 1ps
package fpa_pkg;

   localparam int CMD_BITS = 4;
   localparam int FIELD_BITS = 32;

   localparam logic [CMD_BITS-1:0] CMD_ADD      = 4'd0;
   localparam logic [CMD_BITS-1:0] CMD_SUB      = 4'd1;
   localparam logic [CMD_BITS-1:0] CMD_MUL      = 4'd2;
   localparam logic [CMD_BITS-1:0] CMD_DIV      = 4'd3;
   localparam logic [CMD_BITS-1:0] CMD_MIN      = 4'd4;
   localparam logic [CMD_BITS-1:0] CMD_MAX      = 4'd5;
   localparam logic [CMD_BITS-1:0] CMD_INC      = 4'd6;
   localparam logic [CMD_BITS-1:0] CMD_DEC      = 4'd7;
   localparam logic [CMD_BITS-1:0] CMD_FROM_INT = 4'd8;
   localparam logic [CMD_BITS-1:0] CMD_TO_INT   = 4'd9;

   // Control that travels with each item down the pipeline.
   typedef struct packed {
      logic                valid;
      logic [CMD_BITS-1:0] cmd;
      logic                less;
      logic                equal;
      logic                greater;
      logic                div_zero;
      logic                neg;
   } ctl_type;

endpackage

[design/fpa_req_if.sv]
// Request channel interface of the fixed-point ALU.
`timescale 1ns / 1ps
interface fpa_req_if;
   logic                                   valid;
   logic                                   ready;
   logic [fpa_pkg::CMD_BITS-1:0]           command;
   logic signed [fpa_pkg::FIELD_BITS-1:0]  operand_a;
   logic signed [fpa_pkg::FIELD_BITS-1:0]  operand_b;

   modport source (output valid, command, operand_a, operand_b, input ready);
   modport sink (input valid, command, operand_a, operand_b, output ready);
endinterface

[design/fpa_rsp_if.sv]
// Response channel interface of the fixed-point ALU.
`timescale 1ns / 1ps
interface fpa_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [fpa_pkg::FIELD_BITS-1:0]  result_value;
   logic                                   a_less;
   logic                                   a_equal;
   logic                                   a_greater;
   logic                                   divide_by_zero;

   modport source (output valid, result_value, a_less, a_equal, a_greater, divide_by_zero,
                   input ready);
   modport sink (input valid, result_value, a_less, a_equal, a_greater, divide_by_zero,
                 output ready);
endinterface

[design/fpa_front.sv]
// Entry stage: decode, compare, simple results, multiply and divider setup.
`timescale 1ns / 1ps
module fpa_front #(
   parameter int WORD_BITS = 32,
   parameter int FRAC_BITS = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  en,
   input  logic                                  in_valid,
   input  logic [fpa_pkg::CMD_BITS-1:0]          command,
   input  logic signed [fpa_pkg::FIELD_BITS-1:0] operand_a,
   input  logic signed [fpa_pkg::FIELD_BITS-1:0] operand_b,
   output fpa_pkg::ctl_type                      ctl_ff,
   output logic [WORD_BITS-1:0]                  simple_ff,
   output logic signed [2*WORD_BITS-1:0]         prod_ff,
   output logic [WORD_BITS+FRAC_BITS-1:0]        dq_ff,
   output logic [WORD_BITS-1:0]                  div_ff
);
   localparam int PW = 2 * WORD_BITS;

   logic signed [WORD_BITS-1:0] a_w;
   logic signed [WORD_BITS-1:0] b_w;
   logic [WORD_BITS-1:0]        abs_a;
   logic [WORD_BITS-1:0]        abs_b;
   logic [WORD_BITS-1:0]        simple_in;
   logic signed [PW-1:0]        prod_in;
   fpa_pkg::ctl_type            ctl_in;

   assign a_w = $signed(operand_a[WORD_BITS-1:0]);
   assign b_w = $signed(operand_b[WORD_BITS-1:0]);
   assign abs_a = a_w[WORD_BITS-1] ? WORD_BITS'(-a_w) : WORD_BITS'(a_w);
   assign abs_b = b_w[WORD_BITS-1] ? WORD_BITS'(-b_w) : WORD_BITS'(b_w);
   assign prod_in = PW'(a_w) * PW'(b_w);

   always_comb begin
      case (command)
         fpa_pkg::CMD_ADD:      simple_in = WORD_BITS'(a_w + b_w);
         fpa_pkg::CMD_SUB:      simple_in = WORD_BITS'(a_w - b_w);
         fpa_pkg::CMD_MIN:      simple_in = (a_w < b_w) ? a_w : b_w;
         fpa_pkg::CMD_MAX:      simple_in = (a_w > b_w) ? a_w : b_w;
         fpa_pkg::CMD_INC:      simple_in = WORD_BITS'(a_w) + WORD_BITS'(1);
         fpa_pkg::CMD_DEC:      simple_in = WORD_BITS'(a_w) - WORD_BITS'(1);
         fpa_pkg::CMD_FROM_INT: simple_in = WORD_BITS'(a_w <<< FRAC_BITS);
         fpa_pkg::CMD_TO_INT:   simple_in = WORD_BITS'(a_w >>> FRAC_BITS);
         default:               simple_in = '0;
      endcase
   end

   always_comb begin
      ctl_in.valid    = in_valid;
      ctl_in.cmd      = command;
      ctl_in.less     = a_w < b_w;
      ctl_in.equal    = a_w == b_w;
      ctl_in.greater  = a_w > b_w;
      ctl_in.div_zero = (command == fpa_pkg::CMD_DIV) && (b_w == '0);
      ctl_in.neg      = a_w[WORD_BITS-1] ^ b_w[WORD_BITS-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else if (en) begin
         ctl_ff.valid <= ctl_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ctl_ff.cmd      <= ctl_in.cmd;
         ctl_ff.less     <= ctl_in.less;
         ctl_ff.equal    <= ctl_in.equal;
         ctl_ff.greater  <= ctl_in.greater;
         ctl_ff.div_zero <= ctl_in.div_zero;
         ctl_ff.neg      <= ctl_in.neg;
         simple_ff       <= simple_in;
         prod_ff         <= prod_in;
         dq_ff           <= {abs_a, {FRAC_BITS{1'b0}}};
         div_ff          <= abs_b;
      end
   end
endmodule

[design/fpa_div_step.sv]
// One restoring-division stage that yields a single quotient bit.
`timescale 1ns / 1ps
module fpa_div_step #(
   parameter int WORD_BITS = 32,
   parameter int FRAC_BITS = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 en,
   input  fpa_pkg::ctl_type                     ctl,
   input  logic [WORD_BITS-1:0]                 simple,
   input  logic signed [2*WORD_BITS-1:0]        prod,
   input  logic [WORD_BITS-1:0]                 rem,
   input  logic [WORD_BITS+FRAC_BITS-1:0]       dq,
   input  logic [WORD_BITS-1:0]                 div,
   output fpa_pkg::ctl_type                     ctl_ff,
   output logic [WORD_BITS-1:0]                 simple_ff,
   output logic signed [2*WORD_BITS-1:0]        prod_ff,
   output logic [WORD_BITS-1:0]                 rem_ff,
   output logic [WORD_BITS+FRAC_BITS-1:0]       dq_ff,
   output logic [WORD_BITS-1:0]                 div_ff
);
   localparam int DW = WORD_BITS + FRAC_BITS;

   logic [WORD_BITS:0] trial;
   logic [WORD_BITS:0] diff;
   logic               ge;

   // The remainder stays below the divisor, so the trial value fits one extra bit.
   assign trial = {rem, dq[DW-1]};
   assign diff  = trial - {1'b0, div};
   assign ge    = trial >= {1'b0, div};

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else if (en) begin
         ctl_ff.valid <= ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ctl_ff.cmd      <= ctl.cmd;
         ctl_ff.less     <= ctl.less;
         ctl_ff.equal    <= ctl.equal;
         ctl_ff.greater  <= ctl.greater;
         ctl_ff.div_zero <= ctl.div_zero;
         ctl_ff.neg      <= ctl.neg;
         simple_ff       <= simple;
         prod_ff         <= prod;
         rem_ff          <= ge ? diff[WORD_BITS-1:0] : trial[WORD_BITS-1:0];
         dq_ff           <= {dq[DW-2:0], ge};
         div_ff          <= div;
      end
   end
endmodule

[design/fpa_back.sv]
// Output stage: product scaling, quotient sign, result select and response register.
`timescale 1ns / 1ps
module fpa_back #(
   parameter int WORD_BITS = 32,
   parameter int FRAC_BITS = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           en,
   input  fpa_pkg::ctl_type               ctl,
   input  logic [WORD_BITS-1:0]           simple,
   input  logic signed [2*WORD_BITS-1:0]  prod,
   input  logic [WORD_BITS+FRAC_BITS-1:0] dq,
   fpa_rsp_if.source                      rsp
);
   localparam int PW = 2 * WORD_BITS;
   localparam logic [PW-1:0] BIAS = (PW'(1) << FRAC_BITS) - PW'(1);

   logic signed [PW-1:0]        mul_sum;
   logic signed [PW-1:0]        mul_shift;
   logic [WORD_BITS-1:0]        quot;
   logic [WORD_BITS-1:0]        res_in;
   logic                        valid_ff;
   logic signed [WORD_BITS-1:0] res_ff;
   logic                        less_ff;
   logic                        equal_ff;
   logic                        greater_ff;
   logic                        dz_ff;

   // Biasing a negative product before the shift makes it round toward zero.
   assign mul_sum   = prod + (prod[PW-1] ? BIAS : '0);
   assign mul_shift = mul_sum >>> FRAC_BITS;
   assign quot      = dq[WORD_BITS-1:0];

   always_comb begin
      case (ctl.cmd)
         fpa_pkg::CMD_MUL: res_in = mul_shift[WORD_BITS-1:0];
         fpa_pkg::CMD_DIV: res_in = ctl.div_zero ? '0 : (ctl.neg ? -quot : quot);
         default:          res_in = simple;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff     <= $signed(res_in);
         less_ff    <= ctl.less;
         equal_ff   <= ctl.equal;
         greater_ff <= ctl.greater;
         dz_ff      <= ctl.div_zero;
      end
   end

   assign rsp.valid          = valid_ff;
   assign rsp.result_value   = fpa_pkg::FIELD_BITS'(res_ff);
   assign rsp.a_less         = less_ff;
   assign rsp.a_equal        = equal_ff;
   assign rsp.a_greater      = greater_ff;
   assign rsp.divide_by_zero = dz_ff;
endmodule

[design/fixed_point_alu_core.sv]
// Top level of the pipelined signed fixed-point ALU.
`timescale 1ns / 1ps
// Usage: items enter on the req channel (command, operand_a, operand_b) and one
// result item per request leaves on the rsp channel, in request order. Operands
// are raw two's complement words of WORD_BITS bits with FRAC_BITS fraction bits;
// the upper port bits are ignored and the result is sign-extended to 32 bits.
// The unit takes one item every cycle unless a stalled receiver freezes the
// pipeline, made of one entry stage holding the multiplier, one
// restoring-division stage per quotient bit, and one output register.
// Every command travels the full pipeline so results keep their order.
// Reset (synchronous, active high) clears all stage valid bits; the pipeline is
// empty and ready in the first cycle after reset.
// When the receiver holds rsp.ready low while a result is shown, the whole
// pipeline freezes and req.ready drops; nothing is lost or repeated, and the
// pipeline moves on in the cycle rsp.ready returns.
module fixed_point_alu_core #(
   parameter int WORD_BITS = 32,
   parameter int FRAC_BITS = 8
) (
   input  logic       clock,
   input  logic       reset,
   fpa_req_if.sink    req,
   fpa_rsp_if.source  rsp
);
   localparam int DW = WORD_BITS + FRAC_BITS;

   // Stage i feeds division step i; stage DW feeds the output register.
   fpa_pkg::ctl_type             ctl_s    [DW+1];
   logic [WORD_BITS-1:0]         simple_s [DW+1];
   logic signed [2*WORD_BITS-1:0] prod_s  [DW+1];
   logic [WORD_BITS-1:0]         rem_s    [DW+1];
   logic [DW-1:0]                dq_s     [DW+1];
   logic [WORD_BITS-1:0]         div_s    [DW+1];
   logic                         en;

   // The pipeline advances unless a finished result waits on a stalled receiver.
   assign en        = !rsp.valid || rsp.ready;
   assign req.ready = en;
   assign rem_s[0]  = '0;

   fpa_front #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req.valid),
      .command   (req.command),
      .operand_a (req.operand_a),
      .operand_b (req.operand_b),
      .ctl_ff    (ctl_s[0]),
      .simple_ff (simple_s[0]),
      .prod_ff   (prod_s[0]),
      .dq_ff     (dq_s[0]),
      .div_ff    (div_s[0])
   );

   for (genvar i = 0; i < DW; i++) begin : g_div
      fpa_div_step #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_step (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .ctl       (ctl_s[i]),
         .simple    (simple_s[i]),
         .prod      (prod_s[i]),
         .rem       (rem_s[i]),
         .dq        (dq_s[i]),
         .div       (div_s[i]),
         .ctl_ff    (ctl_s[i+1]),
         .simple_ff (simple_s[i+1]),
         .prod_ff   (prod_s[i+1]),
         .rem_ff    (rem_s[i+1]),
         .dq_ff     (dq_s[i+1]),
         .div_ff    (div_s[i+1])
      );
   end

   // The final remainder and divisor are not needed past the last step.
   fpa_back #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
      .clock  (clock),
      .reset  (reset),
      .en     (en),
      .ctl    (ctl_s[DW]),
      .simple (simple_s[DW]),
      .prod   (prod_s[DW]),
      .dq     (dq_s[DW]),
      .rsp    (rsp)
   );
endmodule
